@@ sv/elf_pkg.sv @@
// Shared types and constants for the eased level fade block.
`timescale 1ns / 1ps

package elf_pkg;

  // Field and fixed-point widths
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned FRAC_W  = 16;               // Q0.16 progress
  localparam int unsigned MUL_W   = FRAC_W + 1;       // eased value reaches 1.0
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned CNT_W   = $clog2(FRAC_W);
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned MODE_W  = 2;

  localparam logic [MUL_W-1:0] ONE_Q = MUL_W'(1) << FRAC_W;

  // Request action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } act_e;

  // Configuration register indexes
  typedef enum logic [CFG_W-1:0] {
    CFG_START_LEVEL  = 2'd0,
    CFG_TARGET_LEVEL = 2'd1,
    CFG_DURATION     = 2'd2,
    CFG_EASING_MODE  = 2'd3
  } cfg_e;

  // Easing curves
  typedef enum logic [MODE_W-1:0] {
    EASE_LINEAR = 2'd0,
    EASE_IN     = 2'd1,
    EASE_OUT    = 2'd2,
    EASE_IN_OUT = 2'd3
  } ease_e;

  // Fade phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_RUNNING  = 2'd1,
    PH_COMPLETE = 2'd2
  } phase_e;

  // Controller states
  typedef enum logic [2:0] {
    S_WAIT   = 3'd0,
    S_DIV    = 3'd1,
    S_SQUARE = 3'd2,
    S_SCALE  = 3'd3,
    S_COMMIT = 3'd4
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // apply the accepted request to the fade state
    logic div_step;   // one restoring divide step
    logic square;     // product <= x * x
    logic scale;      // product <= delta * eased
    logic commit;     // write the new level
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic long_tick;  // accepted tick needs the divide and multiply path
  } dp_stat_t;

endpackage

@@ sv/elf_ctrl.sv @@
// Controller state machine: request handshake, divide step count, result valid.
`timescale 1ns / 1ps

module elf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  elf_pkg::dp_stat_t  stat_i,
  output elf_pkg::ctrl_cmd_t cmd_o
);
  import elf_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             in_accept;

  // A request is taken only when the result slot is empty or draining
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_WAIT) || !slot_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WAIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_WAIT: begin
        if (in_accept) begin
          cmd_o.accept = 1'b1;
          if (stat_i.long_tick) begin
            state_d = S_DIV;
            cnt_d   = '0;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAC_W - 1)) begin
          state_d = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        // slot was freed before this request was taken
        cmd_o.commit = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_WAIT;
      end
      default: begin
        state_d = S_WAIT;
      end
    endcase
  end

endmodule

@@ sv/elf_dp.sv @@
// Datapath: config registers, fade state, restoring divider and shared multiplier.
`timescale 1ns / 1ps

module elf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [elf_pkg::CFG_W-1:0]     cfg_idx_i,
  input  logic [elf_pkg::LEVEL_W-1:0]   cfg_data_i,
  input  logic [elf_pkg::ACT_W-1:0]     action_i,
  input  logic                          from_current_i,
  input  elf_pkg::ctrl_cmd_t            cmd_i,
  output elf_pkg::dp_stat_t             stat_o,
  output logic [elf_pkg::LEVEL_W-1:0]   level_o,
  output logic                          running_o,
  output logic                          complete_o
);
  import elf_pkg::*;

  // Configuration
  logic [LEVEL_W-1:0] start_level_q, target_level_q;
  logic [DUR_W-1:0]   duration_q;
  ease_e              mode_q;

  // Fade state
  phase_e             phase_q;
  logic [DUR_W-1:0]   elapsed_q;
  logic [LEVEL_W-1:0] latched_q, level_q;

  // Work registers
  logic [DUR_W-1:0]   rem_q;
  logic [FRAC_W-1:0]  quo_q;
  logic [PROD_W-1:0]  prod_q;

  logic [DUR_W-1:0]   elapsed_inc;
  logic               tick_done;
  logic [DUR_W:0]     rem_sh;
  logic               quo_bit;
  logic [DUR_W-1:0]   rem_next;
  logic               use_comp;
  logic [MUL_W-1:0]   sq_x;
  logic [MUL_W-1:0]   sq16, sq15;
  logic [MUL_W-1:0]   eased;
  logic               rising;
  logic [LEVEL_W-1:0] delta;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic [LEVEL_W-1:0] scaled;

  // Saturating elapsed count and end-of-fade test
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign tick_done   = (duration_q == '0) || (elapsed_inc >= duration_q);
  assign stat_o.long_tick = (action_i == ACT_TICK) && (phase_q == PH_RUNNING) && !tick_done;

  // Restoring divide step
  assign rem_sh   = {rem_q, 1'b0};
  assign quo_bit  = rem_sh >= {1'b0, duration_q};
  assign rem_next = quo_bit ? DUR_W'(rem_sh - {1'b0, duration_q}) : DUR_W'(rem_sh);

  // Square operand: complement of progress for the falling half curves
  assign use_comp = (mode_q == EASE_OUT) || ((mode_q == EASE_IN_OUT) && quo_q[FRAC_W-1]);
  assign sq_x     = use_comp ? ONE_Q - {1'b0, quo_q} : {1'b0, quo_q};
  assign sq16     = MUL_W'(prod_q >> FRAC_W);
  assign sq15     = MUL_W'(prod_q >> (FRAC_W - 1));

  // Eased progress from the registered square
  always_comb begin
    unique case (mode_q)
      EASE_LINEAR: eased = {1'b0, quo_q};
      EASE_IN:     eased = sq16;
      EASE_OUT:    eased = ONE_Q - sq16;
      EASE_IN_OUT: eased = quo_q[FRAC_W-1] ? ONE_Q - sq15 : sq15;
      default:     eased = {1'b0, quo_q};
    endcase
  end

  // Shared multiplier
  assign rising = target_level_q >= latched_q;
  assign delta  = rising ? target_level_q - latched_q : latched_q - target_level_q;
  assign mul_a  = cmd_i.scale ? eased : sq_x;
  assign mul_b  = cmd_i.scale ? MUL_W'(delta) : sq_x;
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign scaled = LEVEL_W'(prod_q >> FRAC_W);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q  <= '0;
      target_level_q <= '0;
      duration_q     <= '0;
      mode_q         <= EASE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_LEVEL:  start_level_q  <= cfg_data_i;
        CFG_TARGET_LEVEL: target_level_q <= cfg_data_i;
        CFG_DURATION:     duration_q     <= DUR_W'(cfg_data_i);
        CFG_EASING_MODE:  mode_q         <= ease_e'(cfg_data_i[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Fade state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      latched_q <= '0;
      level_q   <= '0;
    end else if (cmd_i.accept) begin
      priority if (action_i == ACT_TICK) begin
        unique case (phase_q)
          PH_IDLE: level_q <= latched_q;
          PH_RUNNING: begin
            elapsed_q <= elapsed_inc;
            if (tick_done) begin
              phase_q <= PH_COMPLETE;
              level_q <= target_level_q;
            end
          end
          default: begin
            phase_q <= PH_COMPLETE;
            level_q <= target_level_q;
          end
        endcase
      end else if (action_i == ACT_START) begin
        latched_q <= from_current_i ? level_q : start_level_q;
        level_q   <= from_current_i ? level_q : start_level_q;
        elapsed_q <= '0;
        phase_q   <= PH_RUNNING;
      end else if (action_i == ACT_STOP) begin
        phase_q <= PH_IDLE;
      end else begin
        // unused action code leaves the state as it is
      end
    end else if (cmd_i.commit) begin
      level_q <= rising ? latched_q + scaled : latched_q - scaled;
    end
  end

  // Divider and multiplier work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q <= elapsed_inc;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[FRAC_W-2:0], quo_bit};
    end
    if (cmd_i.square || cmd_i.scale) begin
      prod_q <= prod_d;
    end
  end

  assign level_o    = level_q;
  assign running_o  = phase_q == PH_RUNNING;
  assign complete_o = phase_q == PH_COMPLETE;

endmodule

@@ sv/eased_level_fade_top.sv @@
// Top level of the eased level fade: controller plus datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  action_i, from_current_i
//   out      output     out_valid_o/out_stall_i level_o, running_o, complete_o
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// A tick mid-fade runs accept, 16 restoring divide steps for the
// progress, one square and one scale on the shared multiplier, then commit.
// Every other request finishes in the cycle it is accepted.
// One request is in work at a time; the next is taken once the result is taken.
// Reset is asynchronous, active low; it clears config, phase and level.
// out_stall_i holds the result and stalls the input side.
`timescale 1ns / 1ps

module eased_level_fade_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [elf_pkg::ACT_W-1:0]   action_i,
  input  logic                        from_current_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [elf_pkg::LEVEL_W-1:0] level_o,
  output logic                        running_o,
  output logic                        complete_o,
  input  logic                        cfg_we_i,
  input  logic [elf_pkg::CFG_W-1:0]   cfg_idx_i,
  input  logic [elf_pkg::LEVEL_W-1:0] cfg_data_i
);
  import elf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  elf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  elf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .from_current_i (from_current_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .level_o        (level_o),
    .running_o      (running_o),
    .complete_o     (complete_o)
  );

endmodule

@@ sv/elf_checker.sv @@
// Port-level checker for the eased level fade, bound to the top level.
`timescale 1ns / 1ps

module elf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [elf_pkg::ACT_W-1:0]   action_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [elf_pkg::LEVEL_W-1:0] level_o,
  input logic                        running_o,
  input logic                        complete_o
);
  import elf_pkg::*;

  // Phase flags exclude each other
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(running_o && complete_o))
    else $error("running and complete both set");

  // Result stays offered while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled level holds
  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(level_o))
    else $error("level changed while stalled");

  // Start request answers next cycle as running
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_START) |=> out_valid_o && running_o)
    else $error("start did not report running");

  // Stop request answers next cycle as idle
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_STOP)
    |=> out_valid_o && !running_o && !complete_o)
    else $error("stop did not report idle");

endmodule

bind eased_level_fade_top elf_checker u_elf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_o     (level_o),
  .running_o   (running_o),
  .complete_o  (complete_o)
);

@@ tb/eased_level_fade_top_tb.sv @@
// Self-checking testbench for eased_level_fade_top: directed table, then random fades.
`timescale 1ns / 1ps

module eased_level_fade_top_tb;
  import elf_pkg::*;

  localparam int CLK_PERIOD = 2;
  localparam int N_ITEMS    = 1300;
  localparam int CALM_ITEMS = 150;    // no idling over the last requests
  localparam int DRAIN_CYC  = 32;     // covers the longest tick, through the divide and multiply path
  localparam int MAX_SHOWN  = 10;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [63:0] ONE_Q16  = 64'd65536;
  localparam logic [63:0] HALF_Q16 = 64'd32768;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               running;
    logic               complete;
  } fade_res_t;

  // One row of the directed table: a register write or a request
  typedef struct {
    bit                 is_cfg;
    cfg_e               idx;
    logic [LEVEL_W-1:0] data;
    logic [ACT_W-1:0]   act;
    logic               fc;
    bit                 typed;
    fade_res_t          res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ACT_W-1:0]   action_i;
  logic               from_current_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [LEVEL_W-1:0] level_o;
  logic               running_o;
  logic               complete_o;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_idx_i;
  logic [LEVEL_W-1:0] cfg_data_i;

  // Typed expectation that travels with the request payload
  logic      req_typed;
  fade_res_t req_res;

  // Predictor copy of registers and fade state
  logic [LEVEL_W-1:0] fade_start_reg;
  logic [LEVEL_W-1:0] fade_target_reg;
  logic [DUR_W-1:0]   fade_dur_reg;
  ease_e              fade_mode_reg;
  phase_e             fade_ph;
  logic [DUR_W-1:0]   fade_elapsed;
  logic [LEVEL_W-1:0] fade_latched;
  logic [LEVEL_W-1:0] fade_level;

  fade_res_t fade_due_q[$];
  dir_row_t  dir_tab[$];
  int        n_mismatch;
  int        n_sent;
  bit        calm;

  eased_level_fade_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .from_current_i (from_current_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .level_o        (level_o),
    .running_o      (running_o),
    .complete_o     (complete_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Q0.16 easing curves
  function automatic logic [63:0] eased_q16(ease_e mode, logic [63:0] t);
    logic [63:0] u;
    case (mode)
      EASE_IN: return (t * t) >> 16;
      EASE_OUT: begin
        u = ONE_Q16 - t;
        return ONE_Q16 - ((u * u) >> 16);
      end
      EASE_IN_OUT: begin
        if (t < HALF_Q16) return (t * t) >> 15;
        u = 2 * (ONE_Q16 - t);
        return ONE_Q16 - ((u * u) >> 17);
      end
      default: return t;
    endcase
  endfunction

  // One millisecond tick of the fade
  function automatic void fade_tick();
    logic [63:0] prog;
    logic [63:0] e;
    logic [63:0] span;
    logic [63:0] step;
    if (fade_ph == PH_IDLE) begin
      fade_level = fade_latched;
      return;
    end
    if (fade_ph != PH_RUNNING) begin
      fade_ph    = PH_COMPLETE;
      fade_level = fade_target_reg;
      return;
    end
    if (fade_elapsed != '1) fade_elapsed = fade_elapsed + 1'b1;
    if (fade_dur_reg == '0 || fade_elapsed >= fade_dur_reg) begin
      fade_ph    = PH_COMPLETE;
      fade_level = fade_target_reg;
      return;
    end
    prog = (64'(fade_elapsed) << 16) / 64'(fade_dur_reg);
    e    = eased_q16(fade_mode_reg, prog);
    span = (fade_target_reg >= fade_latched) ? 64'(fade_target_reg - fade_latched)
                                             : 64'(fade_latched - fade_target_reg);
    step = (span * e) >> 16;
    if (fade_target_reg >= fade_latched) fade_level = fade_latched + step[LEVEL_W-1:0];
    else fade_level = fade_latched - step[LEVEL_W-1:0];
  endfunction

  // Apply one request to the predictor and return the result it should produce
  function automatic fade_res_t fade_apply(logic [ACT_W-1:0] act, logic fc);
    fade_res_t r;
    case (act)
      ACT_TICK: fade_tick();
      ACT_START: begin
        fade_latched = fc ? fade_level : fade_start_reg;
        fade_level   = fade_latched;
        fade_elapsed = '0;
        fade_ph      = PH_RUNNING;
      end
      ACT_STOP: fade_ph = PH_IDLE;
      default: ;
    endcase
    r.level    = fade_level;
    r.running  = (fade_ph == PH_RUNNING);
    r.complete = (fade_ph == PH_COMPLETE);
    return r;
  endfunction

  function automatic void flag_mismatch(string what, fade_res_t want, fade_res_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_SHOWN)
      $display({"%0t mismatch (%0s): want level %h running %b complete %b,",
                " got level %h running %b complete %b"},
               $realtime, what, want.level, want.running, want.complete,
               got.level, got.running, got.complete);
  endfunction

  // Predict on accepted requests and register writes, check accepted results
  always @(posedge clk_i) begin
    fade_res_t got;
    fade_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_LEVEL:  fade_start_reg  = cfg_data_i;
          CFG_TARGET_LEVEL: fade_target_reg = cfg_data_i;
          CFG_DURATION:     fade_dur_reg    = cfg_data_i;
          CFG_EASING_MODE:  fade_mode_reg   = ease_e'(cfg_data_i[MODE_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = fade_apply(action_i, from_current_i);
        fade_due_q.push_back(req_typed ? req_res : want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = {level_o, running_o, complete_o};
        if (fade_due_q.size() == 0) begin
          flag_mismatch("result with no request waiting", '0, got);
        end else begin
          want = fade_due_q.pop_front();
          if (got.level !== want.level || got.running !== want.running ||
              got.complete !== want.complete)
            flag_mismatch("result", want, got);
        end
      end
    end
  end

  // Receiver stalls in random bursts, with quiet stretches
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat (40) @(posedge clk_i);
      end
    end
  end

  // Sender gap of random length now and then
  task automatic in_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Present one request and hold it until accepted
  task automatic send_req(logic [ACT_W-1:0] act, logic fc, bit typed = 1'b0,
                          fade_res_t res = '0);
    in_gap();
    in_valid_i     <= 1'b1;
    action_i       <= act;
    from_current_i <= fc;
    req_typed      <= typed;
    req_res        <= res;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  // Let every pending result come out and the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fade_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [LEVEL_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_reg_value(cfg_e idx);
    case (idx)
      CFG_DURATION: begin
        case ($urandom_range(0, 7))
          0: return '0;
          1: return '1;
          2: return LEVEL_W'($urandom);
          default: return LEVEL_W'($urandom_range(1, 24));
        endcase
      end
      CFG_EASING_MODE: return LEVEL_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return LEVEL_W'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic dir_row_t cfg_row(cfg_e idx, logic [LEVEL_W-1:0] data);
    dir_row_t r;
    r        = '{idx: CFG_START_LEVEL, default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [ACT_W-1:0] act, logic fc);
    dir_row_t r;
    r     = '{idx: CFG_START_LEVEL, default: '0};
    r.act = act;
    r.fc  = fc;
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic [ACT_W-1:0] act, logic fc,
                                       logic [LEVEL_W-1:0] lvl, logic run, logic done);
    dir_row_t r;
    r       = req_row(act, fc);
    r.typed = 1'b1;
    r.res   = '{lvl, run, done};
    return r;
  endfunction

  // A few fades: mostly start plus ticks, some stray requests
  task automatic run_fade_phase();
    int n_ticks;
    int stop_at;
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 7) != 0) begin
        send_req(ACT_START, 1'($urandom));
        n_ticks = $urandom_range(1, 30);
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ticks - 1) : -1;
        for (int k = 0; k < n_ticks; k++)
          send_req((k == stop_at) ? ACT_STOP : ACT_TICK, 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_req(ACT_W'($urandom_range(0, 3)), 1'($urandom));
      end
    end
  endtask

  // Stimulus
  initial begin
    bit first;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = ACT_TICK;
    from_current_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_START_LEVEL;
    cfg_data_i      = '0;
    req_typed       = 1'b0;
    req_res         = '0;
    fade_start_reg  = '0;
    fade_target_reg = '0;
    fade_dur_reg    = '0;
    fade_mode_reg   = EASE_LINEAR;
    fade_ph         = PH_IDLE;
    fade_elapsed    = '0;
    fade_latched    = '0;
    fade_level      = '0;
    n_mismatch      = 0;
    n_sent          = 0;
    calm            = 1'b0;

    dir_tab = '{
      // after reset: idle at zero, unused code changes nothing
      chk_row(ACT_TICK, 1'b0, 16'h0000, 1'b0, 1'b0),
      chk_row(ACT_UNUSED, 1'b1, 16'h0000, 1'b0, 1'b0),
      // full to zero, linear, four ticks
      cfg_row(CFG_START_LEVEL, 16'hFFFF),
      cfg_row(CFG_TARGET_LEVEL, 16'h0000),
      cfg_row(CFG_DURATION, 16'd4),
      cfg_row(CFG_EASING_MODE, 16'(EASE_LINEAR)),
      chk_row(ACT_START, 1'b0, 16'hFFFF, 1'b1, 1'b0),
      req_row(ACT_TICK, 1'b0),
      req_row(ACT_TICK, 1'b1),
      // stop keeps the level, an idle tick returns to the latched start
      req_row(ACT_STOP, 1'b1),
      chk_row(ACT_TICK, 1'b0, 16'hFFFF, 1'b0, 1'b0),
      // restart from the current level and run to completion
      chk_row(ACT_START, 1'b1, 16'hFFFF, 1'b1, 1'b0),
      req_row(ACT_TICK, 1'b0),
      req_row(ACT_TICK, 1'b0),
      req_row(ACT_TICK, 1'b0),
      chk_row(ACT_TICK, 1'b0, 16'h0000, 1'b0, 1'b1),
      chk_row(ACT_TICK, 1'b1, 16'h0000, 1'b0, 1'b1),
      // zero duration completes on the first tick
      cfg_row(CFG_TARGET_LEVEL, 16'hFFFF),
      cfg_row(CFG_DURATION, 16'h0000),
      cfg_row(CFG_EASING_MODE, 16'(EASE_IN_OUT)),
      chk_row(ACT_START, 1'b1, 16'h0000, 1'b1, 1'b0),
      chk_row(ACT_TICK, 1'b0, 16'hFFFF, 1'b0, 1'b1),
      // longest duration, curves switched mid-fade
      cfg_row(CFG_DURATION, 16'hFFFF),
      cfg_row(CFG_EASING_MODE, 16'(EASE_IN)),
      cfg_row(CFG_TARGET_LEVEL, 16'h0000),
      cfg_row(CFG_START_LEVEL, 16'h1234),
      chk_row(ACT_START, 1'b1, 16'hFFFF, 1'b1, 1'b0),
      req_row(ACT_TICK, 1'b0),
      cfg_row(CFG_EASING_MODE, 16'(EASE_OUT)),
      req_row(ACT_TICK, 1'b0),
      cfg_row(CFG_EASING_MODE, 16'(EASE_IN_OUT)),
      req_row(ACT_TICK, 1'b0),
      chk_row(ACT_START, 1'b0, 16'h1234, 1'b1, 1'b0),
      req_row(ACT_TICK, 1'b1),
      req_row(ACT_STOP, 1'b0)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) drain();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_req(dir_tab[i].act, dir_tab[i].fc, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases, registers rewritten while the block is quiet
    first = 1'b1;
    while (n_sent < N_ITEMS) begin
      drain();
      for (int r = 0; r < 4; r++)
        if (first || $urandom_range(0, 1) == 0) write_reg(cfg_e'(r), pick_reg_value(cfg_e'(r)));
      first = 1'b0;
      calm  = (n_sent > N_ITEMS - CALM_ITEMS);
      run_fade_phase();
    end

    drain();
    if (n_mismatch == 0 && fade_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
